>>> hw/rtl/nvf_pkg.sv
// ----------------------------------------------------------------------------
// nvf_pkg: shared types and constants of the NVF mask block
// Payload structs of the request and response channels, register indexes
// of the control port and the status bundle of the result queue.
// ----------------------------------------------------------------------------
package nvf_pkg;

   // Pixel and fraction widths.
   localparam int PIX_W        = 8;
   localparam int FRAC_W       = 16;

   // Control registers.
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int RESET_WIDTH  = 512;
   localparam int RESET_HEIGHT = 512;
   localparam int MAX_HEIGHT   = 4096;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Request word.
   typedef struct packed {
      logic             opcode;
      logic [PIX_W-1:0] pixel;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [FRAC_W-1:0] mask_value;
      logic              frame_last;
   } rsp_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

>>> hw/rtl/nvf_mask_window_variance.sv
// ----------------------------------------------------------------------------
// nvf_mask_window_variance: NVF mask over a square window of a pixel stream
// Raster-order pixels in, one Q0.16 mask value var/(1+var) per pixel out.
//
//   Channel  Direction  Word                       Handshake
//   req      in         opcode, pixel              req_valid / req_ready
//   rsp      out        mask_value, frame_last     rsp_valid / rsp_ready
//   csr      in         csr_index, csr_wdata       csr_valid / csr_ready
//
// A word with no result passes the front states idle and read; one with a
// result passes idle, read, sum, mul and push, then the divider, which retires
// one quotient bit per cycle, pops again once its result is in the output
// register and sets the sustained rate. A four-entry queue separates front
// and divider, and the output register lets the divider go on while a result
// waits. Reset is synchronous and clears all control state at once; the line
// buffer needs no clearing since only rows of the current frame are read.
// ----------------------------------------------------------------------------
module nvf_mask_window_variance #(
   parameter int WINDOW    = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  nvf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output nvf_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nvf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nvf_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int NPIX  = WINDOW * WINDOW;
   localparam int NUM_W = $clog2(NPIX * NPIX * 65025 + 1);

   nvf_pkg::fifo_status_type fifo_status;
   logic                     push_valid;
   logic [NUM_W-1:0]         push_num;
   logic                     push_last;
   logic                     pop;
   logic [NUM_W:0]           pop_data;

   // Window front.
   nvf_front #(
      .WINDOW    (WINDOW),
      .MAX_WIDTH (MAX_WIDTH),
      .NUM_W     (NUM_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .fifo_status (fifo_status),
      .push_valid  (push_valid),
      .push_num    (push_num),
      .push_last   (push_last)
   );

   // Queue between front and divider.
   nvf_fifo #(
      .WIDTH (NUM_W + 1),
      .DEPTH (4)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_last, push_num}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   // Divider back.
   nvf_back #(
      .WINDOW (WINDOW),
      .NUM_W  (NUM_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_status (fifo_status),
      .pop         (pop),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // The front never pushes into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !fifo_status.full)
      else $error("push into full queue");

   // The divider never pops an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("pop from empty queue");

   // A taken word keeps the front busy, so it cannot take a second word back to back.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("front accepted two words back to back");

endmodule

>>> hw/rtl/nvf_ram.sv
// ----------------------------------------------------------------------------
// nvf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nvf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/nvf_fifo.sv
// ----------------------------------------------------------------------------
// nvf_fifo: short queue between the window front and the divider back
// Register-based, first word fall-through.
// ----------------------------------------------------------------------------
module nvf_fifo #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output nvf_pkg::fifo_status_type status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> hw/rtl/nvf_front.sv
// ----------------------------------------------------------------------------
// nvf_front: frame position tracking, line buffer and window statistics
// Accepts one word, updates the line buffer, keeps column sums in a shift
// line and forms the variance numerator N = n*sumsq - sum^2 for the queue.
// ----------------------------------------------------------------------------
module nvf_front #(
   parameter int WINDOW    = 3,
   parameter int MAX_WIDTH = 1024,
   parameter int NUM_W     = 28
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nvf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nvf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  nvf_pkg::req_type                     req_data,
   input  nvf_pkg::fifo_status_type             fifo_status,
   output logic                                 push_valid,
   output logic [NUM_W-1:0]                     push_num,
   output logic                                 push_last
);

   localparam int HALF   = (WINDOW - 1) / 2;
   localparam int NPIX   = WINDOW * WINDOW;
   localparam int PW     = nvf_pkg::PIX_W;
   localparam int AW     = $clog2(MAX_WIDTH);
   localparam int CW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = nvf_pkg::HEIGHT_REG_W;
   localparam int TOT_W  = CW + HW;
   localparam int POS_W  = TOT_W + 1;
   localparam int XW     = CW + 2;
   localparam int LW     = PW * (WINDOW - 1);
   localparam int CSUM_W = $clog2(WINDOW * 255 + 1);
   localparam int CSQ_W  = $clog2(WINDOW * 65025 + 1);
   localparam int SUM_W  = $clog2(NPIX * 255 + 1);
   localparam int SQ_W   = $clog2(NPIX * 65025 + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;

   logic [2:0]                        state_ff, state_in;
   logic [nvf_pkg::WIDTH_REG_W-1:0]   width_ff;
   logic [HW-1:0]                     height_ff;
   logic [CW-1:0]                     w_eff;
   logic [HW-1:0]                     h_eff;
   logic [TOT_W-1:0]                  total_ff;
   logic [POS_W-1:0]                  lat_ff;
   logic [AW-1:0]                     in_col_ff;
   logic [HW-1:0]                     in_row_ff;
   logic [POS_W-1:0]                  pos_ff;
   logic [TOT_W-1:0]                  out_count_ff;
   logic [AW-1:0]                     out_col_ff;
   logic                              accept;
   logic                              csr_write;
   logic                              produce;
   logic                              is_last;
   logic                              col_wrap;
   logic                              ocol_wrap;
   // Item held while it moves through the stages.
   logic [PW-1:0]                     pix_ff;
   logic [HW-1:0]                     qr_ff;
   logic [AW-1:0]                     col_ff;
   logic [AW-1:0]                     oc_ff;
   logic                              produce_ff;
   logic                              last_ff;
   // Line buffer.
   logic [LW-1:0]                     ram_rdata;
   logic [LW-1:0]                     ram_wdata;
   logic [PW-1:0]                     elem [WINDOW];
   logic [CSUM_W-1:0]                 col_sum;
   logic [CSQ_W-1:0]                  col_sq;
   logic [CSUM_W-1:0]                 cs_ff [WINDOW];
   logic [CSQ_W-1:0]                  cq_ff [WINDOW];
   logic [XW-1:0]                     oc_x;
   logic [SUM_W-1:0]                  win_sum;
   logic [SQ_W-1:0]                   win_sq;
   logic [SUM_W-1:0]                  sum_ff;
   logic [SQ_W-1:0]                   sq_ff;
   logic [NUM_W-1:0]                  a_ff;
   logic [NUM_W-1:0]                  b_ff;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready &&
                      (csr_index == nvf_pkg::CSR_IMAGE_WIDTH ||
                       csr_index == nvf_pkg::CSR_IMAGE_HEIGHT);
   assign req_ready = (state_ff == ST_IDLE) && !fifo_status.full;
   assign accept    = req_valid && req_ready;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= nvf_pkg::WIDTH_REG_W'(nvf_pkg::RESET_WIDTH);
         height_ff <= HW'(nvf_pkg::RESET_HEIGHT);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == nvf_pkg::CSR_IMAGE_WIDTH) begin
            width_ff <= csr_wdata[nvf_pkg::WIDTH_REG_W-1:0];
         end else if (csr_index == nvf_pkg::CSR_IMAGE_HEIGHT) begin
            height_ff <= csr_wdata[HW-1:0];
         end
      end
   end

   // Clamped frame size.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = CW'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = HW'(1);
      end else if (int'(height_ff) > nvf_pkg::MAX_HEIGHT) begin
         h_eff = HW'(nvf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // Frame size and latency follow the registers in the next cycle.
   always_ff @(posedge clock) begin
      total_ff <= TOT_W'(w_eff) * TOT_W'(h_eff);
      lat_ff   <= POS_W'(w_eff) * POS_W'(HALF) + POS_W'(HALF);
   end

   // Position of the incoming word and of the next result.
   assign produce   = (pos_ff >= lat_ff);
   assign is_last   = (out_count_ff == total_ff - TOT_W'(1));
   assign col_wrap  = ((CW + 1)'(in_col_ff) + (CW + 1)'(1) >= (CW + 1)'(w_eff));
   assign ocol_wrap = ((CW + 1)'(out_col_ff) + (CW + 1)'(1) >= (CW + 1)'(w_eff));

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         pos_ff       <= '0;
         out_count_ff <= '0;
         out_col_ff   <= '0;
      end else if (accept) begin
         if (produce && is_last) begin
            in_col_ff    <= '0;
            in_row_ff    <= '0;
            pos_ff       <= '0;
            out_count_ff <= '0;
            out_col_ff   <= '0;
         end else begin
            pos_ff <= pos_ff + POS_W'(1);
            if (col_wrap) begin
               in_col_ff <= '0;
               in_row_ff <= in_row_ff + HW'(1);
            end else begin
               in_col_ff <= in_col_ff + AW'(1);
            end
            if (produce) begin
               out_count_ff <= out_count_ff + TOT_W'(1);
               out_col_ff   <= ocol_wrap ? '0 : out_col_ff + AW'(1);
            end
         end
      end
   end

   // Latch the accepted word; a flush or a word past the frame reads as zero.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff     <= (in_row_ff < h_eff && !req_data.opcode) ? req_data.pixel : '0;
         qr_ff      <= in_row_ff;
         col_ff     <= in_col_ff;
         oc_ff      <= out_col_ff;
         produce_ff <= produce;
         last_ff    <= is_last;
      end
   end

   // Line buffer holds the previous WINDOW-1 rows, one byte per row.
   nvf_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (col_ff),
      .wr_data (ram_wdata),
      .rd_addr (in_col_ff),
      .rd_data (ram_rdata)
   );

   // Column vector with rows above the frame forced to zero.
   always_comb begin
      elem[0] = pix_ff;
      for (int j = 1; j < WINDOW; j++) begin
         elem[j] = (int'(qr_ff) >= j) ? ram_rdata[PW*(j-1) +: PW] : '0;
      end
      for (int j = 0; j < WINDOW - 1; j++) begin
         ram_wdata[PW*j +: PW] = elem[j];
      end
      col_sum = '0;
      col_sq  = '0;
      for (int j = 0; j < WINDOW; j++) begin
         col_sum = col_sum + CSUM_W'(elem[j]);
         col_sq  = col_sq + CSQ_W'(elem[j]) * CSQ_W'(elem[j]);
      end
   end

   // Column sums shift in as each word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            cs_ff[k] <= '0;
            cq_ff[k] <= '0;
         end
      end else if (state_ff == ST_READ) begin
         cs_ff[0] <= col_sum;
         cq_ff[0] <= col_sq;
         for (int k = 1; k < WINDOW; k++) begin
            cs_ff[k] <= cs_ff[k-1];
            cq_ff[k] <= cq_ff[k-1];
         end
      end
   end

   // Window sums; columns beyond the left or right edge are dropped.
   assign oc_x = XW'(oc_ff) + XW'(HALF);

   always_comb begin
      win_sum = '0;
      win_sq  = '0;
      for (int k = 0; k < WINDOW; k++) begin
         if (oc_x >= XW'(k) && oc_x < XW'(w_eff) + XW'(k)) begin
            win_sum = win_sum + SUM_W'(cs_ff[k]);
            win_sq  = win_sq + SQ_W'(cq_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUM) begin
         sum_ff <= win_sum;
         sq_ff  <= win_sq;
      end
      if (state_ff == ST_MUL) begin
         a_ff <= NUM_W'(sq_ff) * NUM_W'(NPIX);
         b_ff <= NUM_W'(sum_ff) * NUM_W'(sum_ff);
      end
   end

   // Stage sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_READ;
         ST_READ: state_in = produce_ff ? ST_SUM : ST_IDLE;
         ST_SUM:  state_in = ST_MUL;
         ST_MUL:  state_in = ST_PUSH;
         ST_PUSH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign push_valid = (state_ff == ST_PUSH);
   assign push_num   = a_ff - b_ff;
   assign push_last  = last_ff;

endmodule

>>> hw/rtl/nvf_back.sv
// ----------------------------------------------------------------------------
// nvf_back: restoring divider and output register
// Computes floor(2^16 * N / (N + D)) one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nvf_back #(
   parameter int WINDOW = 3,
   parameter int NUM_W  = 28
) (
   input  logic                     clock,
   input  logic                     reset,
   input  nvf_pkg::fifo_status_type fifo_status,
   output logic                     pop,
   input  logic [NUM_W:0]           pop_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output nvf_pkg::rsp_type         rsp_data
);

   localparam int NPIX = WINDOW * WINDOW;
   localparam int FW   = nvf_pkg::FRAC_W;
   localparam int KW   = $clog2(FW + 1);
   localparam int DW   = NUM_W + 1;

   logic             busy_ff;
   logic [KW-1:0]    cnt_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    den_ff;
   logic [FW-1:0]    quo_ff;
   logic             last_ff;
   logic             rsp_valid_ff;
   nvf_pkg::rsp_type rsp_ff;
   logic [DW:0]      rem_shift;
   logic             fits;
   logic             done;
   logic             load_out;

   assign pop       = !busy_ff && !fifo_status.empty;
   assign rem_shift = {rem_ff, 1'b0};
   assign fits      = (rem_shift >= (DW + 1)'(den_ff));
   assign done      = busy_ff && (cnt_ff == KW'(FW));
   assign load_out  = done && (!rsp_valid_ff || rsp_ready);

   // Divider control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (load_out) begin
         busy_ff <= 1'b0;
      end else if (busy_ff && !done) begin
         cnt_ff <= cnt_ff + KW'(1);
      end
   end

   // Divider datapath; the remainder stays below the divisor.
   always_ff @(posedge clock) begin
      if (pop) begin
         rem_ff  <= DW'(pop_data[NUM_W-1:0]);
         den_ff  <= DW'(pop_data[NUM_W-1:0]) + DW'(NPIX * (NPIX - 1));
         last_ff <= pop_data[NUM_W];
         quo_ff  <= '0;
      end else if (busy_ff && !done) begin
         rem_ff <= fits ? DW'(rem_shift - (DW + 1)'(den_ff)) : DW'(rem_shift);
         quo_ff <= {quo_ff[FW-2:0], fits};
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff.mask_value <= quo_ff;
         rsp_ff.frame_last <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
